>>> sv/matrix_keypad_scan_debounce_macros.svh
// Assertion macros for the keypad scanner RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MATRIX_KEYPAD_SCAN_DEBOUNCE_MACROS_SVH
`define MATRIX_KEYPAD_SCAN_DEBOUNCE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset
`define MKPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad scanner check failed");
// Next-cycle implication, checked outside reset
`define MKPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad scanner check failed");
`else
`define MKPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MKPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/mkpd_pkg.sv
// Shared types and constants for the matrix keypad scanner.
// No dependencies; used by mkpd_debounce, the top module and the testbench.
package mkpd_pkg;

    // Configuration register indexes
    localparam logic CFG_KEY_ENABLE  = 1'b0;
    localparam logic CFG_VALID_COUNT = 1'b1;

    localparam logic        KEY_ENABLE_RST  = 1'b1;
    localparam logic [15:0] VALID_COUNT_RST = 16'd6;

    localparam int ROM_SIZE = 24;

    // Scan position to key position code
    localparam logic [4:0] POS_ROM [ROM_SIZE] = '{
        5'd17, 5'd5,  5'd18, 5'd14, 5'd0,  5'd1,  5'd16, 5'd12,
        5'd21, 5'd23, 5'd3,  5'd4,  5'd15, 5'd11, 5'd7,  5'd22,
        5'd2,  5'd9,  5'd20, 5'd10, 5'd6,  5'd19, 5'd13, 5'd8
    };

    // Input transaction
    typedef struct packed {
        logic [3:0] row_lines;
        logic       power_line;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic [2:0] column_drive;
        logic       key_event;
        logic [4:0] key_code;
        logic       power_event;
    } t_out_item;

    // Debounce counter control
    typedef struct packed {
        logic advance;  // end-of-scan tick
        logic hold;     // same key still held, keep counting
    } t_dbc_cmd;

    // Codes past the ROM pass through unchanged
    function automatic logic [4:0] pos_code(input logic [4:0] code);
        logic [4:0] res;
        if (code < 5'(ROM_SIZE)) begin
            res = POS_ROM[code];
        end else begin
            res = code;
        end
        return res;
    endfunction

endpackage

>>> sv/mkpd_scan.sv
// Row decode and per-scan code latch for the keypad scanner.
// Uses no items of mkpd_pkg; its widths match the package by convention.
module mkpd_scan #(
    parameter int NUM_COLUMNS = 6,
    parameter int NUM_ROWS    = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic       i_last,
    input  logic [3:0] i_rows,
    input  logic [2:0] i_col,
    output logic       o_code_valid,
    output logic [4:0] o_code
);

    logic       r_valid;
    logic [4:0] r_code;
    logic       w_hit;
    logic [4:0] w_hit_code;

    // A row counts only when it is the single low line
    always_comb begin
        w_hit      = 1'b0;
        w_hit_code = '0;
        for (int r = 0; r < NUM_ROWS && r < 4; r++) begin
            if (i_rows == (4'hF & ~(4'b0001 << r))) begin
                w_hit      = 1'b1;
                w_hit_code = 5'(r * NUM_COLUMNS) + 5'(i_col);
            end
        end
    end

    // Latched code as seen at the end of this tick
    assign o_code_valid = w_hit || r_valid;
    assign o_code       = w_hit ? w_hit_code : r_code;

    // Latch; cleared after the last column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            if (i_last) begin
                r_valid <= 1'b0;
            end else if (w_hit) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_hit) begin
            r_code <= w_hit_code;
        end
    end

endmodule

>>> sv/mkpd_debounce.sv
// Saturating hold counter that fires when the count reaches the threshold.
// Depends on mkpd_pkg for the control struct.
module mkpd_debounce #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mkpd_pkg::t_dbc_cmd i_cmd,
    input  logic [15:0]       i_valid_count,
    output logic              o_hit
);

    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [COUNT_WIDTH-1:0] w_inc;
    logic                   w_sat;

    assign w_inc = r_cnt + COUNT_WIDTH'(1);
    assign w_sat = (r_cnt == {COUNT_WIDTH{1'b1}});

    // Report only on the increment that lands on the threshold
    assign o_hit = i_cmd.advance && i_cmd.hold && !w_sat
                   && (16'(w_inc) == i_valid_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.advance) begin
            if (!i_cmd.hold) begin
                r_cnt <= '0;
            end else if (!w_sat) begin
                r_cnt <= w_inc;
            end
        end
    end

endmodule

>>> sv/matrix_keypad_scan_debounce.sv
// Matrix keypad scanner with debounce. One input transaction is one scan tick:
// the four active-low row lines sampled for the column driven during that tick,
// plus the power-key line. Every transaction yields exactly one result, which
// carries the column to drive on the next tick and any debounced key report.
// The block takes one transaction per clock while the output is not stalled; an input
// register is followed by a result register, with all decode and counting done in
// one combinational pass between them. Stall on the output backs up through the
// input register. Configuration (key_enable, valid_count) uses a plain write port,
// to be written only while no transaction is in flight; the block does not enforce it.
// Depends on mkpd_pkg, mkpd_scan, mkpd_debounce and the assertion macro header.
`include "matrix_keypad_scan_debounce_macros.svh"

module matrix_keypad_scan_debounce #(
    parameter int NUM_COLUMNS = 6,
    parameter int NUM_ROWS    = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  mkpd_pkg::t_in_item  i_item,
    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output mkpd_pkg::t_out_item o_item,
    // configuration
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_wdata
);

    logic                r_key_enable;
    logic [15:0]         r_valid_count;
    logic                r_in_valid;
    mkpd_pkg::t_in_item  r_in;
    logic                r_out_valid;
    mkpd_pkg::t_out_item r_out;
    logic [2:0]          r_col;
    logic                r_held_valid;
    logic [4:0]          r_held_code;
    logic                r_power_seen;

    logic                w_out_free;
    logic                w_adv;
    logic                w_in_acc;
    logic                w_last;
    logic [2:0]          n_col;
    logic                w_code_valid;
    logic [4:0]          w_code;
    logic                w_same;
    logic                w_key_hit;
    logic                w_pwr_hit;
    mkpd_pkg::t_dbc_cmd  w_key_cmd;
    mkpd_pkg::t_dbc_cmd  w_pwr_cmd;
    mkpd_pkg::t_out_item n_out;

    // Handshake
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_in_acc   = i_valid && !o_stall;
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_enable  <= mkpd_pkg::KEY_ENABLE_RST;
            r_valid_count <= mkpd_pkg::VALID_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mkpd_pkg::CFG_KEY_ENABLE:  r_key_enable  <= i_cfg_wdata[0];
                mkpd_pkg::CFG_VALID_COUNT: r_valid_count <= i_cfg_wdata;
                default:                   r_key_enable  <= r_key_enable;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_item;
        end
    end

    // Column sequencing
    assign w_last = (r_col == 3'(NUM_COLUMNS - 1));
    assign n_col  = w_last ? 3'd0 : r_col + 3'd1;

    mkpd_scan #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_last       (w_last),
        .i_rows       (r_in.row_lines),
        .i_col        (r_col),
        .o_code_valid (w_code_valid),
        .o_code       (w_code)
    );

    // Matrix key debounce
    assign w_same            = w_code_valid && r_held_valid && (r_held_code == w_code);
    assign w_key_cmd.advance = w_adv && w_last;
    assign w_key_cmd.hold    = w_same;

    mkpd_debounce #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_key_dbc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_key_cmd),
        .i_valid_count (r_valid_count),
        .o_hit         (w_key_hit)
    );

    // Power key debounce
    assign w_pwr_cmd.advance = w_adv && w_last;
    assign w_pwr_cmd.hold    = !r_in.power_line && r_power_seen;

    mkpd_debounce #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_pwr_dbc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_pwr_cmd),
        .i_valid_count (r_valid_count),
        .o_hit         (w_pwr_hit)
    );

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_held_valid <= 1'b0;
            r_held_code  <= '1;
            r_power_seen <= 1'b0;
        end else if (w_adv) begin
            r_col <= n_col;
            if (w_last) begin
                r_power_seen <= !r_in.power_line;
                if (!w_code_valid) begin
                    r_held_valid <= 1'b0;
                end else if (!w_same) begin
                    r_held_valid <= 1'b1;
                    r_held_code  <= w_code;
                end
            end
        end
    end

    // Result assembly
    always_comb begin
        n_out.column_drive = n_col;
        n_out.key_event    = w_key_hit && r_key_enable;
        n_out.key_code     = n_out.key_event ? mkpd_pkg::pos_code(w_code) : 5'd0;
        n_out.power_event  = w_pwr_hit;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // Reports happen only at the end of a scan, so the next column is zero
    `MKPD_ASSERT_IMP(a_evt_wraps, i_clk, i_rst_n, r_out_valid && (r_out.key_event || r_out.power_event), r_out.column_drive == 3'd0)
    // No key report means a zero code
    `MKPD_ASSERT_IMP(a_code_zero, i_clk, i_rst_n, r_out_valid && !r_out.key_event, r_out.key_code == 5'd0)
    // A stalled pending tick is still pending next cycle
    `MKPD_ASSERT_NXT(a_stall_keeps, i_clk, i_rst_n, o_stall, r_in_valid && r_out_valid)
    // Held code present whenever a key report is made
    `MKPD_ASSERT_NXT(a_evt_held, i_clk, i_rst_n, w_adv && w_key_hit, r_held_valid)

endmodule

>>> sim/matrix_keypad_scan_debounce_test.sv
// Self-checking testbench for the matrix keypad scanner with debounce.
// Depends on mkpd_pkg and matrix_keypad_scan_debounce; drives scan ticks, predicts each
// result in place unless the table gives it; compares field by field with DUT output.
module matrix_keypad_scan_debounce_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS       = 6;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 300;

    // One row of the directed table; res is used only when typed is set
    typedef struct packed {
        logic [3:0]          rows;
        logic                pwr;
        logic                typed;
        mkpd_pkg::t_out_item res;
    } t_dir_row;

    // One register setting for a stretch of random traffic
    typedef struct packed {
        logic        en;
        logic [15:0] vc;
        logic [15:0] count;
    } t_phase;

    // Directed ticks, run with valid_count = 1 and keys enabled
    localparam int NDIR = 24;
    localparam t_dir_row DIRECTED [NDIR] = '{
        // scan 1: row 0 hit on column 0, then several-low, none-low and noise
        {4'b1110, 1'b1, 1'b1, {3'd1, 1'b0, 5'd0, 1'b0}},
        {4'b0000, 1'b1, 1'b0, 10'd0},
        {4'b1111, 1'b0, 1'b0, 10'd0},
        {4'b1100, 1'b1, 1'b0, 10'd0},
        {4'b1111, 1'b1, 1'b0, 10'd0},
        {4'b1111, 1'b0, 1'b1, {3'd0, 1'b0, 5'd0, 1'b0}},
        // scan 2: same key again, power still held: both report
        {4'b1110, 1'b1, 1'b0, 10'd0},
        {4'b1111, 1'b1, 1'b0, 10'd0},
        {4'b1111, 1'b1, 1'b0, 10'd0},
        {4'b1111, 1'b1, 1'b0, 10'd0},
        {4'b1001, 1'b1, 1'b0, 10'd0},
        {4'b1111, 1'b0, 1'b1, {3'd0, 1'b1, 5'd17, 1'b1}},
        // scan 3: two hits, the last one (row 3, column 5) wins; new key, no report
        {4'b1111, 1'b1, 1'b0, 10'd0},
        {4'b1111, 1'b1, 1'b0, 10'd0},
        {4'b1110, 1'b1, 1'b0, 10'd0},
        {4'b1111, 1'b1, 1'b0, 10'd0},
        {4'b1111, 1'b1, 1'b0, 10'd0},
        {4'b0111, 1'b0, 1'b1, {3'd0, 1'b0, 5'd0, 1'b0}},
        // scan 4: highest code held again, power released
        {4'b1111, 1'b0, 1'b0, 10'd0},
        {4'b1111, 1'b1, 1'b0, 10'd0},
        {4'b1111, 1'b0, 1'b0, 10'd0},
        {4'b1111, 1'b1, 1'b0, 10'd0},
        {4'b1111, 1'b1, 1'b0, 10'd0},
        {4'b0111, 1'b1, 1'b1, {3'd0, 1'b1, 5'd8, 1'b0}}
    };

    // Random traffic settings; extremes of both registers included
    localparam int NPH = 8;
    localparam t_phase PHASES [NPH] = '{
        {1'b1, 16'd2,     16'd150},
        {1'b0, 16'd1,     16'd120},
        {1'b1, 16'd1,     16'd150},
        {1'b1, 16'd3,     16'd150},
        {1'b1, 16'd0,     16'd100},
        {1'b1, 16'hFFFF,  16'd100},
        {1'b0, 16'd2,     16'd100},
        {1'b1, 16'd4,     16'd130}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    mkpd_pkg::t_in_item  i_item;
    logic                o_valid;
    logic                i_stall;
    mkpd_pkg::t_out_item o_item;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [15:0]         i_cfg_wdata;

    matrix_keypad_scan_debounce DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Clock, 12 ns period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Scanner state as predicted
    logic        key_en;
    logic [15:0] valid_cnt;
    logic [2:0]  col_idx;
    logic [4:0]  latch_code;
    logic        latch_ok;
    logic [4:0]  held_code;
    logic        held_ok;
    logic [15:0] hold_cnt;
    logic        pwr_seen;
    logic [15:0] pwr_cnt;

    // Stimulus generator state
    logic [1:0]  key_row;
    logic [2:0]  key_col;
    logic        key_down;
    int          key_scans;
    logic        pwr_down;
    int          pwr_scans;

    mkpd_pkg::t_out_item scan_result_q [$];
    int          errors;
    int          results_seen;
    int          quiet_cycles;
    bit          calm;
    bit          long_done;
    int          stall_left;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want,
                 results_seen);
        errors++;
    endtask

    // Saturating debounce count; true on the step that lands on valid_count
    function automatic bit count_held(inout logic [15:0] cnt);
        if (cnt != 16'hFFFF) begin
            cnt = cnt + 16'd1;
            return cnt == valid_cnt;
        end
        return 1'b0;
    endfunction

    function automatic void clear_scanner();
        key_en     = mkpd_pkg::KEY_ENABLE_RST;
        valid_cnt  = mkpd_pkg::VALID_COUNT_RST;
        col_idx    = '0;
        latch_code = 5'd31;
        latch_ok   = 1'b0;
        held_code  = 5'd31;
        held_ok    = 1'b0;
        hold_cnt   = '0;
        pwr_seen   = 1'b0;
        pwr_cnt    = '0;
    endfunction

    // One scan tick: decode rows, debounce at end of scan, advance the column
    function automatic mkpd_pkg::t_out_item scan_tick(input mkpd_pkg::t_in_item it);
        mkpd_pkg::t_out_item res;
        logic [3:0]          pat;
        int                  r;
        res = '0;
        for (r = 0; r < 4; r++) begin
            pat = ~(4'b0001 << r);
            if (it.row_lines == pat) begin
                latch_code = 5'(r * COLS + int'(col_idx));
                latch_ok   = 1'b1;
            end
        end
        if (col_idx == 3'(COLS - 1)) begin
            if (!latch_ok) begin
                held_ok   = 1'b0;
                held_code = 5'd31;
                hold_cnt  = '0;
            end else if (held_ok && held_code == latch_code) begin
                if (count_held(hold_cnt) && key_en) begin
                    res.key_event = 1'b1;
                    res.key_code  = mkpd_pkg::POS_ROM[latch_code];
                end
            end else begin
                held_code = latch_code;
                held_ok   = 1'b1;
                hold_cnt  = '0;
            end
            latch_ok   = 1'b0;
            latch_code = 5'd31;
            // power key, debounced alike but never gated
            if (!it.power_line) begin
                if (pwr_seen) begin
                    if (count_held(pwr_cnt)) begin
                        res.power_event = 1'b1;
                    end
                end else begin
                    pwr_seen = 1'b1;
                    pwr_cnt  = '0;
                end
            end else begin
                pwr_seen = 1'b0;
                pwr_cnt  = '0;
            end
        end
        col_idx = (col_idx == 3'(COLS - 1)) ? 3'd0 : col_idx + 3'd1;
        res.column_drive = col_idx;
        return res;
    endfunction

    // Random tick: mostly keys held for a few scans, some noise on top
    function automatic mkpd_pkg::t_in_item next_random_tick();
        mkpd_pkg::t_in_item it;
        int                 span;
        span = (valid_cnt >= 16'd1 && valid_cnt <= 16'd5) ? int'(valid_cnt) + 3 : 6;
        if (col_idx == 3'd0) begin
            if (key_scans == 0) begin
                key_down  = ($urandom_range(0, 7) != 0);
                key_row   = 2'($urandom_range(0, 3));
                key_col   = 3'($urandom_range(0, COLS - 1));
                key_scans = $urandom_range(1, span);
            end
            key_scans--;
            if (pwr_scans == 0) begin
                pwr_down  = ($urandom_range(0, 2) == 0);
                pwr_scans = $urandom_range(1, span);
            end
            pwr_scans--;
        end
        it.row_lines  = 4'hF;
        it.power_line = !pwr_down;
        if (key_down && col_idx == key_col) begin
            it.row_lines = ~(4'b0001 << key_row);
        end
        if ($urandom_range(0, 11) == 0) begin
            it.row_lines = 4'($urandom_range(0, 15));
        end
        if ($urandom_range(0, 19) == 0) begin
            it.power_line = !it.power_line;
        end
        return it;
    endfunction

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == mkpd_pkg::CFG_KEY_ENABLE) begin
            key_en = val[0];
        end else begin
            valid_cnt = val;
        end
    endtask

    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
    endtask

    // Offer one tick, wait for the handshake, then predict its result
    task automatic send_scan(input mkpd_pkg::t_in_item it, input bit typed,
                             input mkpd_pkg::t_out_item want);
        mkpd_pkg::t_out_item pred;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pred = scan_tick(it);
        scan_result_q.push_back(typed ? want : pred);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (scan_result_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Main stimulus
    initial begin
        mkpd_pkg::t_in_item it;
        int                 k;
        int                 p;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = mkpd_pkg::CFG_KEY_ENABLE;
        i_cfg_wdata = '0;
        calm        = 1'b0;
        key_scans   = 0;
        pwr_scans   = 0;
        key_down    = 1'b0;
        pwr_down    = 1'b0;
        key_row     = '0;
        key_col     = '0;
        clear_scanner();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        write_reg(mkpd_pkg::CFG_VALID_COUNT, 16'd1);
        for (k = 0; k < NDIR; k++) begin
            sender_gap();
            it.row_lines  = DIRECTED[k].rows;
            it.power_line = DIRECTED[k].pwr;
            send_scan(it, DIRECTED[k].typed, DIRECTED[k].res);
        end

        // random traffic, one register setting per phase
        for (p = 0; p < NPH; p++) begin
            drain_results();
            write_reg(mkpd_pkg::CFG_KEY_ENABLE, {15'd0, PHASES[p].en});
            write_reg(mkpd_pkg::CFG_VALID_COUNT, PHASES[p].vc);
            calm = (p == NPH - 1);
            for (k = 0; k < int'(PHASES[p].count); k++) begin
                sender_gap();
                it = next_random_tick();
                send_scan(it, 1'b0, '0);
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (scan_result_q.size() != 0) begin
            report_mismatch("results missing", 0, scan_result_q.size());
        end
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, none at the end
    initial begin
        i_stall    = 1'b0;
        long_done  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!calm && !long_done && results_seen >= 400) begin
                long_done  = 1'b1;
                stall_left = LONG_HOLD - 1;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Result checker and activity count for the watchdog
    initial begin
        errors       = 0;
        results_seen = 0;
        quiet_cycles = 0;
    end

    always @(posedge i_clk) begin
        mkpd_pkg::t_out_item want;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (o_valid && !i_stall) begin
                if (scan_result_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = scan_result_q.pop_front();
                    if (o_item.column_drive !== want.column_drive) begin
                        report_mismatch("column_drive", o_item.column_drive,
                                        want.column_drive);
                    end
                    if (o_item.key_event !== want.key_event) begin
                        report_mismatch("key_event", o_item.key_event, want.key_event);
                    end
                    if (o_item.key_code !== want.key_code) begin
                        report_mismatch("key_code", o_item.key_code, want.key_code);
                    end
                    if (o_item.power_event !== want.power_event) begin
                        report_mismatch("power_event", o_item.power_event,
                                        want.power_event);
                    end
                end
                results_seen++;
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    initial begin
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/mkpd_pkg.sv
sv/mkpd_scan.sv
sv/mkpd_debounce.sv
sv/matrix_keypad_scan_debounce.sv
sim/matrix_keypad_scan_debounce_test.sv
